// ===== hw/rtl/dcb_pkg.sv =====
`timescale 1ns / 1ps

package dcb_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int ST_W      = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_LIST       = 3'd6;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

endpackage

// ===== hw/rtl/deque_circular_buffer.sv =====
`timescale 1ns / 1ps

// Double-ended queue of DEPTH signed 32-bit words in a ring held in one
// synchronous RAM. Each input word is one operation (push, pop or peek at
// either end, or list). Push results skip the RAM read; pop and peek wait
// for the registered RAM read; list issues one RAM read per word, front to
// rear, pausing while the output register is held, with out_last on the
// final one. An empty queue answers pop, peek and list with a single
// status-empty word, a full queue refuses a push with status full, and
// action code 7 is dropped without a result. One operation is in flight
// at a time; a new one is taken once the output register is free or being drained.

module deque_circular_buffer
  import dcb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] in_action,
  input  word_t            in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output word_t            out_value_res,
  output logic             out_last
);

  localparam int IDX_W = $clog2(DEPTH);

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  word_t            mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  word_t            mem_rd_data;

  dcb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_res (out_value_res),
    .out_last      (out_last),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

  dcb_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== hw/rtl/dcb_mem.sv =====
`timescale 1ns / 1ps

module dcb_mem
  import dcb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  word_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output word_t            rd_data
);

  word_t mem [DEPTH];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds when no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/dcb_ctrl.sv =====
`timescale 1ns / 1ps

module dcb_ctrl
  import dcb_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] in_action,
  input  word_t            in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output word_t            out_value_res,
  output logic             out_last,
  output logic             mem_wr_en,
  output logic [IDX_W-1:0] mem_wr_addr,
  output word_t            mem_wr_data,
  output logic             mem_rd_en,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  word_t            mem_rd_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r;
  word_t            out_value_r;
  logic             out_last_r;

  logic             can_load;
  logic             accept;
  logic             ld;
  logic [ST_W-1:0]  ld_status;
  word_t            ld_value;
  logic             ld_last;

  assign can_load = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && can_load;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    rem_nxt     = rem_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = head_r;
    mem_wr_data = in_value;
    mem_rd_en   = 1'b0;
    mem_rd_addr = head_r;
    ld          = 1'b0;
    ld_status   = ST_OK;
    ld_value    = '0;
    ld_last     = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action inside {ACT_PUSH_FRONT, ACT_PUSH_REAR}) begin
            ld = 1'b1;
            if (count_r == CNT_FULL) begin
              ld_status = ST_FULL;
            end else begin
              mem_wr_en = 1'b1;
              count_nxt = count_r + CNT_ONE;
              if (count_r == '0) begin
                head_nxt    = '0;
                tail_nxt    = '0;
                mem_wr_addr = '0;
              end else if (in_action == ACT_PUSH_FRONT) begin
                head_nxt    = ring_prev(head_r);
                mem_wr_addr = ring_prev(head_r);
              end else begin
                tail_nxt    = ring_next(tail_r);
                mem_wr_addr = ring_next(tail_r);
              end
            end
          end else if (in_action inside {ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT,
                                         ACT_PEEK_REAR, ACT_LIST}) begin
            if (count_r == '0) begin
              ld        = 1'b1;
              ld_status = ST_EMPTY;
            end else begin
              mem_rd_en = 1'b1;
              case (in_action)
                ACT_POP_FRONT: begin
                  mem_rd_addr = head_r;
                  count_nxt   = count_r - CNT_ONE;
                  head_nxt    = (count_r == CNT_ONE) ? '0 : ring_next(head_r);
                  tail_nxt    = (count_r == CNT_ONE) ? '0 : tail_r;
                  state_nxt   = S_READ;
                end
                ACT_POP_REAR: begin
                  mem_rd_addr = tail_r;
                  count_nxt   = count_r - CNT_ONE;
                  tail_nxt    = (count_r == CNT_ONE) ? '0 : ring_prev(tail_r);
                  head_nxt    = (count_r == CNT_ONE) ? '0 : head_r;
                  state_nxt   = S_READ;
                end
                ACT_PEEK_FRONT: begin
                  mem_rd_addr = head_r;
                  state_nxt   = S_READ;
                end
                ACT_PEEK_REAR: begin
                  mem_rd_addr = tail_r;
                  state_nxt   = S_READ;
                end
                default: begin
                  mem_rd_addr = head_r;
                  idx_nxt     = ring_next(head_r);
                  rem_nxt     = count_r;
                  state_nxt   = S_LIST;
                end
              endcase
            end
          end
        end
      end
      S_READ: begin
        ld        = 1'b1;
        ld_value  = mem_rd_data;
        state_nxt = S_IDLE;
      end
      S_LIST: begin
        if (can_load) begin
          ld       = 1'b1;
          ld_value = mem_rd_data;
          ld_last  = (rem_r == CNT_ONE);
          if (rem_r == CNT_ONE) begin
            state_nxt = S_IDLE;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_r;
            idx_nxt     = ring_next(idx_r);
            rem_nxt     = rem_r - CNT_ONE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status_r <= ld_status;
      out_value_r  <= ld_value;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_res = out_value_r;
  assign out_last      = out_last_r;

endmodule
